### src/bra_pkg.sv
// Shared types and codes for the bitmap run block allocator.
// Holds the command and result transaction types, operation and status codes.
// No dependencies.
`default_nettype none
package bra_pkg;

	localparam int WORD_W = 8;

	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_FREE   = 2'd1;
	localparam logic [1:0] FN_SINGLE = 2'd2;
	localparam logic [1:0] FN_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOM   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FREED = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [10:0] run_length;
		logic [9:0]  block_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  run_start;
		logic [10:0] free_blocks;
		logic [10:0] longest_free_run;
	} rsp_t;

endpackage
`default_nettype wire

### src/bra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/bitmap_run_block_allocator.sv
// First-fit contiguous block allocator over a used/free bitmap held in a RAM.
// Depends on bra_pkg and bra_ram.
//
// The bitmap lives in a RAM of 8-bit words and every command that is not rejected walks
// it one word per cycle. A query reads every word of the pool; an allocation scans the
// words until the first fitting run ends and then rewrites the words the run covers; a
// run free rewrites the covered words; a single free rewrites the one word that holds
// its block; rejected commands answer without touching the map. After reset and after
// every total_blocks write the block sweeps all ceil(MAX_BLOCKS/8) words of the RAM to
// zero with busy high. A total_blocks write is taken only while the block is idle and
// start is low. Results appear for one cycle with done high and cannot be stalled.
`default_nettype none
module bitmap_run_block_allocator #(
	parameter int MAX_BLOCKS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire bra_pkg::cmd_t cmd,
	output logic               done,
	output bra_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [10:0]   cfg_data
);
	import bra_pkg::*;

	localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IW     = (AW + 3 > 12) ? AW + 3 : 12;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_RMW   = 2'd3;

	function automatic logic [10:0] clamp_total(input logic [10:0] v);
		logic [10:0] r;
		r = v;
		if (r == 11'd0) r = 11'd1;
		if (int'(r) > MAX_BLOCKS) r = 11'(MAX_BLOCKS);
		return r;
	endfunction

	logic [1:0]    state_q;
	logic [10:0]   total_q, free_q;
	logic [AW-1:0] ptr_q, wa_s1;
	logic          iss_q, pend_s1, done_q;
	logic [10:0]   cur_q, best_q, len_q, max_q;
	logic [IW-1:0] lo_q, hi_q;
	logic [1:0]    op_q, status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;

	logic [IW-1:0] tot_iw, base, endp;
	logic [AW-1:0] last_w, hi_w, end_w;
	logic [10:0]   c_n, best_n;
	logic          fnd;
	logic [WORD_W-1:0] mask, new_word;
	logic [3:0]    cnt;
	logic [IW-1:0] idx_iw, fr_end;

	assign tot_iw = IW'(total_q);
	assign base   = IW'(wa_s1) << 3;
	assign last_w = AW'((tot_iw - IW'(1)) >> 3);
	assign hi_w   = AW'(hi_q >> 3);
	assign end_w  = (state_q == S_SCAN) ? last_w : hi_w;
	assign idx_iw = IW'(cmd.block_index);
	assign fr_end = idx_iw + IW'(cmd.run_length);

	always_comb begin
		logic [IW-1:0] pos;
		logic          u;
		c_n    = cur_q;
		best_n = best_q;
		fnd    = 1'b0;
		endp   = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pos = base + IW'(b);
			u   = ram_rdata[b] | (pos >= tot_iw);
			if (!fnd) begin
				if (u) begin
					c_n = 11'd0;
				end else begin
					c_n = c_n + 11'd1;
					if (c_n > best_n) best_n = c_n;
					if (op_q == FN_ALLOC && c_n >= len_q) begin
						fnd  = 1'b1;
						endp = pos;
					end
				end
			end
		end
	end

	always_comb begin
		logic [IW-1:0] pos;
		mask = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pos     = base + IW'(b);
			mask[b] = (pos >= lo_q) && (pos <= hi_q);
		end
		new_word = (op_q == FN_ALLOC) ? (ram_rdata | mask) : (ram_rdata & ~mask);
		cnt = 4'd0;
		for (int b = 0; b < WORD_W; b++) begin
			cnt = cnt + 4'(ram_rdata[b] & mask[b]);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_RMW && pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = new_word;
		end
	end

	bra_ram #(.WIDTH(WORD_W), .DEPTH(NWORDS), .AW(AW)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q   <= '0;
			total_q <= clamp_total(11'd1024);
			free_q  <= clamp_total(11'd1024);
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			iss_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			total_q <= clamp_total(cfg_data);
			free_q  <= clamp_total(cfg_data);
			state_q <= S_CLEAR;
			ptr_q   <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			iss_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == AW'(NWORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q     <= cmd.func;
						len_q    <= cmd.run_length;
						cur_q    <= '0;
						best_q   <= '0;
						iss_q    <= 1'b1;
						pend_s1  <= 1'b0;
						status_q <= ST_OK;
						max_q    <= '0;
						lo_q     <= '0;
						case (cmd.func)
							FN_ALLOC: begin
								ptr_q <= '0;
								if (cmd.run_length == 11'd0) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else if (cmd.run_length > free_q) begin
									status_q <= ST_OOM;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							FN_FREE: begin
								ptr_q <= AW'(idx_iw >> 3);
								lo_q  <= idx_iw;
								hi_q  <= fr_end - IW'(1);
								if (cmd.run_length == 11'd0 || fr_end > tot_iw) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RMW;
								end
							end
							FN_SINGLE: begin
								ptr_q <= AW'(idx_iw >> 3);
								lo_q  <= idx_iw;
								hi_q  <= idx_iw;
								if (idx_iw >= tot_iw) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_RMW;
								end
							end
							default: begin
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN, S_RMW: begin
					pend_s1 <= iss_q;
					wa_s1   <= ptr_q;
					if (iss_q) begin
						ptr_q <= ptr_q + AW'(1);
						if (ptr_q == end_w) iss_q <= 1'b0;
					end
					if (pend_s1 && state_q == S_SCAN) begin
						cur_q  <= c_n;
						best_q <= best_n;
						if (fnd) begin
							lo_q    <= endp + IW'(1) - IW'(len_q);
							hi_q    <= endp;
							ptr_q   <= AW'((endp + IW'(1) - IW'(len_q)) >> 3);
							iss_q   <= 1'b1;
							pend_s1 <= 1'b0;
							state_q <= S_RMW;
						end else if (wa_s1 == last_w) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (op_q == FN_ALLOC) begin
								status_q <= ST_OOM;
							end else begin
								max_q <= best_n;
							end
						end
					end
					if (pend_s1 && state_q == S_RMW) begin
						if (op_q != FN_ALLOC) free_q <= free_q + 11'(cnt);
						if (wa_s1 == hi_w) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (op_q == FN_ALLOC) begin
								free_q <= free_q - len_q;
							end else if (op_q == FN_SINGLE && cnt == 4'd0) begin
								status_q <= ST_FREED;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign done      = done_q;

	always_comb begin
		rsp.status           = status_q;
		rsp.run_start        = (status_q == ST_OK && op_q == FN_ALLOC) ? 10'(lo_q) : 10'd0;
		rsp.free_blocks      = free_q;
		rsp.longest_free_run = max_q;
	end

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= total_q) else $error("free count above block count");
	a_write_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW && pend_s1) |-> wa_s1 <= last_w)
		else $error("map write past the pool");
	a_start_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_valid) |=> (busy || done))
		else $error("accepted transaction neither busy nor answered");
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.run_start == 10'd0)
		else $error("run start given for failed transaction");
endmodule
`default_nettype wire

### verif/bitmap_run_block_allocator_tb.sv
// Testbench for bitmap_run_block_allocator: directed and random commands checked
// against a behavioral predictor of the bitmap and free count.
// Depends on bra_pkg and the allocator RTL.
`default_nettype none
module bitmap_run_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bra_pkg::*;

	localparam int MAXB = 1024;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	bit          used_blk [MAXB];
	int          free_cnt;
	int          total_blks;
	rsp_t        expected_rsp [$];
	int          err_cnt = 0;
	int          gap_pct = 0;
	int          stall_cnt = 0;

	bitmap_run_block_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void pool_set_total(input logic [10:0] v);
		int t;
		t = v;
		if (t < 1) t = 1;
		if (t > MAXB) t = MAXB;
		total_blks = t;
		foreach (used_blk[i]) used_blk[i] = 1'b0;
		free_cnt = t;
	endfunction

	function automatic rsp_t alloc_predict(input cmd_t c);
		rsp_t r;
		int len, idx, run, i, best;
		bit found;
		r = '0;
		r.status = ST_OK;
		len = c.run_length;
		idx = c.block_index;
		run = 0;
		found = 1'b0;
		best = 0;
		case (c.func)
			FN_ALLOC: begin
				if (len == 0) r.status = ST_RANGE;
				else if (len > free_cnt) r.status = ST_OOM;
				else begin
					for (i = 0; i < total_blks; i++) begin
						run = used_blk[i] ? 0 : run + 1;
						if (run >= len) begin
							found = 1'b1;
							break;
						end
					end
					if (found) begin
						r.run_start = 10'(i + 1 - len);
						for (int k = i + 1 - len; k <= i; k++) used_blk[k] = 1'b1;
						free_cnt -= len;
					end else r.status = ST_OOM;
				end
			end
			FN_FREE: begin
				if (len == 0 || idx + len > total_blks) r.status = ST_RANGE;
				else begin
					for (i = idx; i < idx + len; i++) begin
						if (used_blk[i]) begin
							used_blk[i] = 1'b0;
							free_cnt++;
						end
					end
				end
			end
			FN_SINGLE: begin
				if (idx >= total_blks) r.status = ST_RANGE;
				else if (!used_blk[idx]) r.status = ST_FREED;
				else begin
					used_blk[idx] = 1'b0;
					free_cnt++;
				end
			end
			default: begin
				for (i = 0; i < total_blks; i++) begin
					run = used_blk[i] ? 0 : run + 1;
					if (run > best) best = run;
				end
				r.longest_free_run = 11'(best);
			end
		endcase
		r.free_blocks = 11'(free_cnt);
		return r;
	endfunction

	task automatic send_cmd(input logic [1:0] f, input int len, input int idx);
		cmd_t c;
		c.func = f;
		c.run_length = 11'(len);
		c.block_index = 10'(idx);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		cmd = c;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp.push_back(alloc_predict(c));
	endtask

	task automatic write_total(input logic [10:0] v);
		@(negedge clk);
		start = 1'b0;
		wait (expected_rsp.size() == 0);
		repeat (300) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pool_set_total(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				$error("result with nothing expected");
				err_cnt++;
			end else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					err_cnt++;
				end
				if (rsp.run_start !== e.run_start) begin
					$error("run_start expected %0d actual %0d", e.run_start, rsp.run_start);
					err_cnt++;
				end
				if (rsp.free_blocks !== e.free_blocks) begin
					$error("free_blocks expected %0d actual %0d", e.free_blocks,
						rsp.free_blocks);
					err_cnt++;
				end
				if (rsp.longest_free_run !== e.longest_free_run) begin
					$error("longest_free_run expected %0d actual %0d",
						e.longest_free_run, rsp.longest_free_run);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_cmd(FN_QUERY, 0, 0);
		send_cmd(FN_ALLOC, 0, 0);
		send_cmd(FN_ALLOC, 2047, 0);
		send_cmd(FN_ALLOC, 1024, 0);
		send_cmd(FN_ALLOC, 1, 0);
		send_cmd(FN_QUERY, 0, 0);
		send_cmd(FN_FREE, 0, 5);
		send_cmd(FN_FREE, 2, 1023);
		send_cmd(FN_SINGLE, 1023, 1023);
		send_cmd(FN_SINGLE, 0, 1023);
		send_cmd(FN_FREE, 10, 100);
		send_cmd(FN_FREE, 20, 95);
		send_cmd(FN_ALLOC, 40, 0);
		send_cmd(FN_ALLOC, 25, 0);
		send_cmd(FN_QUERY, 0, 0);
		send_cmd(FN_FREE, 1024, 0);
		send_cmd(FN_QUERY, 0, 0);
		write_total(11'd10);
		send_cmd(FN_SINGLE, 0, 10);
		send_cmd(FN_SINGLE, 0, 3);
		send_cmd(FN_FREE, 5, 6);
		send_cmd(FN_ALLOC, 11, 0);
		send_cmd(FN_ALLOC, 10, 0);
		send_cmd(FN_QUERY, 0, 0);
	endtask

	task automatic test_config_extremes();
		logic [10:0] vals [4] = '{11'd0, 11'd1, 11'd2047, 11'd1025};
		foreach (vals[i]) begin
			write_total(vals[i]);
			send_cmd(FN_ALLOC, 1, 0);
			send_cmd(FN_ALLOC, 1, 0);
			send_cmd(FN_SINGLE, 0, 0);
			send_cmd(FN_QUERY, 0, 0);
		end
	endtask

	task automatic test_random(input int n_items, input int pct);
		int f, len, idx, p;
		gap_pct = pct;
		write_total($urandom_range(3) == 0 ? 11'd1024 : 11'($urandom_range(1, 96)));
		repeat (n_items) begin
			p = $urandom_range(99);
			f = p < 40 ? FN_ALLOC : p < 65 ? FN_FREE : p < 85 ? FN_SINGLE : FN_QUERY;
			p = $urandom_range(99);
			len = p < 85 ? $urandom_range(1, 16) : p < 95 ? $urandom_range(1, total_blks)
				: $urandom_range(2047);
			idx = $urandom_range(9) != 0 ? $urandom_range(total_blks - 1) : $urandom_range(1023);
			send_cmd(f[1:0], len, idx);
		end
	endtask

	initial begin
		pool_set_total(11'd1024);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		test_random(500, 17);
		test_random(500, 74);
		test_random(500, 0);
		@(negedge clk);
		start = 1'b0;
		wait (expected_rsp.size() == 0);
		repeat (300) @(posedge clk);
		if (err_cnt == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
src/bra_pkg.sv
src/bra_ram.sv
src/bitmap_run_block_allocator.sv
verif/bitmap_run_block_allocator_tb.sv
